FILE: sv/ldf_pkg.sv
// ----------------------------------------------------------------------------
// ldf_pkg
// Types, tables and helper functions shared by the luma deblocking edge filter.
// ----------------------------------------------------------------------------
package ldf_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned QP_W     = 6;
  localparam int unsigned BS_W     = 3;
  localparam int unsigned OFS_W    = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned TC0_W    = 5;
  localparam int unsigned BETA_W   = 5;

  localparam logic [QP_W-1:0] QP_MAX = 6'd51;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_OFFSET  = 1'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] p3_in;
    logic [SAMPLE_W-1:0] p2_in;
    logic [SAMPLE_W-1:0] p1_in;
    logic [SAMPLE_W-1:0] p0_in;
    logic [SAMPLE_W-1:0] q0_in;
    logic [SAMPLE_W-1:0] q1_in;
    logic [SAMPLE_W-1:0] q2_in;
    logic [SAMPLE_W-1:0] q3_in;
    logic [BS_W-1:0]     bs;
    logic [QP_W-1:0]     qp;
  } ldf_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] p2_out;
    logic [SAMPLE_W-1:0] p1_out;
    logic [SAMPLE_W-1:0] p0_out;
    logic [SAMPLE_W-1:0] q0_out;
    logic [SAMPLE_W-1:0] q1_out;
    logic [SAMPLE_W-1:0] q2_out;
    logic                filtered;
  } ldf_out_t;

  // candidate values produced ahead of the final clip and select
  typedef struct packed {
    logic signed [8:0]   dp1;  // unclipped p1 correction
    logic signed [8:0]   dq1;  // unclipped q1 correction
    logic signed [8:0]   dlt;  // unclipped edge delta
    logic [SAMPLE_W-1:0] sp0;
    logic [SAMPLE_W-1:0] sp1;
    logic [SAMPLE_W-1:0] sp2;
    logic [SAMPLE_W-1:0] sq0;
    logic [SAMPLE_W-1:0] sq1;
    logic [SAMPLE_W-1:0] sq2;
    logic [SAMPLE_W-1:0] wp0;
    logic [SAMPLE_W-1:0] wq0;
  } ldf_cand_t;

  localparam logic [7:0] ALPHA_TAB [52] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd4, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10,
    8'd12, 8'd13, 8'd15, 8'd17, 8'd20, 8'd22, 8'd25, 8'd28,
    8'd32, 8'd36, 8'd40, 8'd45, 8'd50, 8'd56, 8'd63, 8'd71,
    8'd80, 8'd90, 8'd101, 8'd113, 8'd127, 8'd144, 8'd162, 8'd182,
    8'd203, 8'd226, 8'd255, 8'd255
  };

  localparam logic [BETA_W-1:0] BETA_TAB [52] = '{
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
    5'd2, 5'd2, 5'd2, 5'd3, 5'd3, 5'd3, 5'd3, 5'd4,
    5'd4, 5'd4, 5'd6, 5'd6, 5'd7, 5'd7, 5'd8, 5'd8,
    5'd9, 5'd9, 5'd10, 5'd10, 5'd11, 5'd11, 5'd12, 5'd12,
    5'd13, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15, 5'd16, 5'd16,
    5'd17, 5'd17, 5'd18, 5'd18
  };

  localparam logic [TC0_W-1:0] TC0_TAB [52][3] = '{
    '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd0},
    '{5'd0, 5'd0, 5'd0}, '{5'd0, 5'd0, 5'd1}, '{5'd0, 5'd0, 5'd1}, '{5'd0, 5'd0, 5'd1},
    '{5'd0, 5'd0, 5'd1}, '{5'd0, 5'd1, 5'd1}, '{5'd0, 5'd1, 5'd1}, '{5'd1, 5'd1, 5'd1},
    '{5'd1, 5'd1, 5'd1}, '{5'd1, 5'd1, 5'd1}, '{5'd1, 5'd1, 5'd1}, '{5'd1, 5'd1, 5'd2},
    '{5'd1, 5'd1, 5'd2}, '{5'd1, 5'd1, 5'd2}, '{5'd1, 5'd1, 5'd2}, '{5'd1, 5'd2, 5'd3},
    '{5'd1, 5'd2, 5'd3}, '{5'd2, 5'd2, 5'd3}, '{5'd2, 5'd2, 5'd4}, '{5'd2, 5'd3, 5'd4},
    '{5'd2, 5'd3, 5'd4}, '{5'd3, 5'd3, 5'd5}, '{5'd3, 5'd4, 5'd6}, '{5'd3, 5'd4, 5'd6},
    '{5'd4, 5'd5, 5'd7}, '{5'd4, 5'd5, 5'd8}, '{5'd4, 5'd6, 5'd9}, '{5'd5, 5'd7, 5'd10},
    '{5'd6, 5'd8, 5'd11}, '{5'd6, 5'd8, 5'd13}, '{5'd7, 5'd10, 5'd14}, '{5'd8, 5'd11, 5'd16},
    '{5'd9, 5'd12, 5'd18}, '{5'd10, 5'd13, 5'd20}, '{5'd11, 5'd15, 5'd23},
    '{5'd13, 5'd17, 5'd25}
  };

  function automatic logic [QP_W-1:0] clip_idx(input logic signed [7:0] s);
    logic [QP_W-1:0] r;
    if (s < 8'sd0) begin
      r = '0;
    end else if (s > $signed({2'b00, QP_MAX})) begin
      r = QP_MAX;
    end else begin
      r = s[QP_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] abs_diff(input logic [SAMPLE_W-1:0] a,
                                                   input logic [SAMPLE_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // clip a signed value to -lim..lim, lim never negative
  function automatic logic signed [8:0] clip_sym(input logic signed [8:0] v,
                                                 input logic signed [8:0] lim);
    logic signed [8:0] r;
    if (v < -lim) begin
      r = -lim;
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] clip_pix(input logic signed [9:0] v);
    logic [SAMPLE_W-1:0] r;
    if (v < 10'sd0) begin
      r = '0;
    end else if (v > 10'sd255) begin
      r = 8'd255;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/ldf_filt_math.sv
// ----------------------------------------------------------------------------
// ldf_filt_math
// Candidate arithmetic for the normal and strong luma edge filters.
// ----------------------------------------------------------------------------
module ldf_filt_math import ldf_pkg::*; (
  input  ldf_in_t   smp,
  output ldf_cand_t cand
);

  logic [8:0]         avg_sum;
  logic [7:0]         avg;
  logic signed [9:0]  p1_t;
  logic signed [9:0]  q1_t;
  logic signed [11:0] dlt_t;
  logic [10:0]        so0, so2, sr0, sr2;
  logic [9:0]         so1, sr1, wo0, wr0;

  always_comb begin
    avg_sum = 9'(smp.p0_in) + 9'(smp.q0_in) + 9'd1;
    avg     = avg_sum[8:1];

    p1_t = $signed({2'b00, smp.p2_in}) + $signed({2'b00, avg})
         - $signed({1'b0, smp.p1_in, 1'b0});
    q1_t = $signed({2'b00, smp.q2_in}) + $signed({2'b00, avg})
         - $signed({1'b0, smp.q1_in, 1'b0});

    dlt_t = (($signed({4'b0000, smp.q0_in}) - $signed({4'b0000, smp.p0_in})) <<< 2)
          + $signed({4'b0000, smp.p1_in}) - $signed({4'b0000, smp.q1_in}) + 12'sd4;

    so0 = 11'(smp.p2_in) + (11'(smp.p1_in) << 1) + (11'(smp.p0_in) << 1)
        + (11'(smp.q0_in) << 1) + 11'(smp.q1_in) + 11'd4;
    so1 = 10'(smp.p2_in) + 10'(smp.p1_in) + 10'(smp.p0_in) + 10'(smp.q0_in) + 10'd2;
    so2 = (11'(smp.p3_in) << 1) + 11'(smp.p2_in) + (11'(smp.p2_in) << 1)
        + 11'(smp.p1_in) + 11'(smp.p0_in) + 11'(smp.q0_in) + 11'd4;
    sr0 = 11'(smp.p1_in) + (11'(smp.p0_in) << 1) + (11'(smp.q0_in) << 1)
        + (11'(smp.q1_in) << 1) + 11'(smp.q2_in) + 11'd4;
    sr1 = 10'(smp.p0_in) + 10'(smp.q0_in) + 10'(smp.q1_in) + 10'(smp.q2_in) + 10'd2;
    sr2 = (11'(smp.q3_in) << 1) + 11'(smp.q2_in) + (11'(smp.q2_in) << 1)
        + 11'(smp.q1_in) + 11'(smp.q0_in) + 11'(smp.p0_in) + 11'd4;
    wo0 = (10'(smp.p1_in) << 1) + 10'(smp.p0_in) + 10'(smp.q1_in) + 10'd2;
    wr0 = (10'(smp.q1_in) << 1) + 10'(smp.q0_in) + 10'(smp.p1_in) + 10'd2;

    // dropping low bits of a signed value rounds toward minus infinity
    cand.dp1 = p1_t[9:1];
    cand.dq1 = q1_t[9:1];
    cand.dlt = dlt_t[11:3];
    cand.sp0 = so0[10:3];
    cand.sp1 = so1[9:2];
    cand.sp2 = so2[10:3];
    cand.sq0 = sr0[10:3];
    cand.sq1 = sr1[9:2];
    cand.sq2 = sr2[10:3];
    cand.wp0 = wo0[9:2];
    cand.wq0 = wr0[9:2];
  end

endmodule

FILE: sv/luma_deblock_edge_filter_top.sv
// ----------------------------------------------------------------------------
// luma_deblock_edge_filter_top
// H.264 luma deblocking filter for one line of eight samples across an edge.
// ----------------------------------------------------------------------------
// One line enters per clock unless the pipe is stalled, and its result passes
// four register stages: index clipping, table lookup with sample differences,
// edge decisions with filter arithmetic, and the final clip and select, which
// is also the output register. Each stage holds its item only while the stage
// after it is full and stalled, so gaps in the pipe are filled even while a
// result waits at the output. Offsets are taken as written and should change
// only while the pipe is empty.
module luma_deblock_edge_filter_top import ldf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ldf_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ldf_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [OFS_W-1:0]     cfg_wdata
);

  logic signed [OFS_W-1:0] alpha_ofs_r, beta_ofs_r;

  logic rdy2, rdy3, rdy4;
  logic v1_r, v2_r, v3_r, v4_r;

  // stage 1
  ldf_in_t          s1_data_r;
  logic [QP_W-1:0]  ia_r, ib_r, ia_nxt, ib_nxt;
  logic signed [7:0] ia_sum, ib_sum;

  // stage 2
  ldf_in_t           s2_data_r;
  logic [7:0]        alpha_r, alpha_nxt;
  logic [BETA_W-1:0] beta_r, beta_nxt;
  logic [TC0_W-1:0]  tc0_r, tc0_nxt;
  logic [1:0]        tc_col;
  logic [7:0]        ad_p0q0_r, ad_p1p0_r, ad_q1q0_r, ad_p2p0_r, ad_q2q0_r;

  // stage 3
  ldf_in_t          s3_data_r;
  ldf_cand_t        cand, cand_r;
  logic             filt_r, normal_r, ap_r, aq_r, strong_r;
  logic             filt_nxt, ap_nxt, aq_nxt, strong_nxt;
  logic [TC0_W-1:0] tc0_3_r;
  logic [7:0]       beta_ext, strong_thr;

  // stage 4
  ldf_out_t          out_r, out_nxt;
  logic signed [8:0] tc0_s, tc_s, dp1_c, dq1_c, d_c;
  logic signed [9:0] p0_d, q0_d;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_ofs_r <= '0;
      beta_ofs_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALPHA_OFFSET: alpha_ofs_r <= $signed(cfg_wdata);
        REG_BETA_OFFSET:  beta_ofs_r  <= $signed(cfg_wdata);
        default:          ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign in_ready = !v1_r || rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (in_ready) v1_r <= in_valid;
      if (rdy2)     v2_r <= v1_r;
      if (rdy3)     v3_r <= v2_r;
      if (rdy4)     v4_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_comb begin
    ia_sum = $signed({2'b00, in_data.qp}) + $signed({{3{alpha_ofs_r[OFS_W-1]}}, alpha_ofs_r});
    ib_sum = $signed({2'b00, in_data.qp}) + $signed({{3{beta_ofs_r[OFS_W-1]}}, beta_ofs_r});
    ia_nxt = clip_idx(ia_sum);
    ib_nxt = clip_idx(ib_sum);
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_data_r <= in_data;
      ia_r      <= ia_nxt;
      ib_r      <= ib_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    unique case (s1_data_r.bs)
      3'd2:    tc_col = 2'd1;
      3'd3:    tc_col = 2'd2;
      default: tc_col = 2'd0;
    endcase
    alpha_nxt = ALPHA_TAB[ia_r];
    beta_nxt  = BETA_TAB[ib_r];
    tc0_nxt   = TC0_TAB[ia_r][tc_col];
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_data_r <= s1_data_r;
      alpha_r   <= alpha_nxt;
      beta_r    <= beta_nxt;
      tc0_r     <= tc0_nxt;
      ad_p0q0_r <= abs_diff(s1_data_r.p0_in, s1_data_r.q0_in);
      ad_p1p0_r <= abs_diff(s1_data_r.p1_in, s1_data_r.p0_in);
      ad_q1q0_r <= abs_diff(s1_data_r.q1_in, s1_data_r.q0_in);
      ad_p2p0_r <= abs_diff(s1_data_r.p2_in, s1_data_r.p0_in);
      ad_q2q0_r <= abs_diff(s1_data_r.q2_in, s1_data_r.q0_in);
    end
  end

  // ---------------------------------------------------------------- stage 3
  ldf_filt_math u_math (
    .smp  (s2_data_r),
    .cand (cand)
  );

  always_comb begin
    beta_ext   = {3'b000, beta_r};
    strong_thr = {2'b00, alpha_r[7:2]} + 8'd2;
    filt_nxt   = (s2_data_r.bs != '0) && (ad_p0q0_r < alpha_r)
              && (ad_p1p0_r < beta_ext) && (ad_q1q0_r < beta_ext);
    ap_nxt     = ad_p2p0_r < beta_ext;
    aq_nxt     = ad_q2q0_r < beta_ext;
    strong_nxt = ad_p0q0_r < strong_thr;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_data_r <= s2_data_r;
      cand_r    <= cand;
      filt_r    <= filt_nxt;
      normal_r  <= !s2_data_r.bs[2];
      ap_r      <= ap_nxt;
      aq_r      <= aq_nxt;
      strong_r  <= strong_nxt;
      tc0_3_r   <= tc0_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  always_comb begin
    tc0_s = $signed({4'b0000, tc0_3_r});
    tc_s  = tc0_s + $signed({8'd0, ap_r}) + $signed({8'd0, aq_r});
    dp1_c = clip_sym(cand_r.dp1, tc0_s);
    dq1_c = clip_sym(cand_r.dq1, tc0_s);
    d_c   = clip_sym(cand_r.dlt, tc_s);
    p0_d  = $signed({2'b00, s3_data_r.p0_in}) + $signed({d_c[8], d_c});
    q0_d  = $signed({2'b00, s3_data_r.q0_in}) - $signed({d_c[8], d_c});

    out_nxt.p2_out   = s3_data_r.p2_in;
    out_nxt.p1_out   = s3_data_r.p1_in;
    out_nxt.p0_out   = s3_data_r.p0_in;
    out_nxt.q0_out   = s3_data_r.q0_in;
    out_nxt.q1_out   = s3_data_r.q1_in;
    out_nxt.q2_out   = s3_data_r.q2_in;
    out_nxt.filtered = filt_r;

    if (filt_r && normal_r) begin
      if (ap_r) out_nxt.p1_out = s3_data_r.p1_in + dp1_c[7:0];
      if (aq_r) out_nxt.q1_out = s3_data_r.q1_in + dq1_c[7:0];
      out_nxt.p0_out = clip_pix(p0_d);
      out_nxt.q0_out = clip_pix(q0_d);
    end else if (filt_r) begin
      if (strong_r && ap_r) begin
        out_nxt.p0_out = cand_r.sp0;
        out_nxt.p1_out = cand_r.sp1;
        out_nxt.p2_out = cand_r.sp2;
      end else begin
        out_nxt.p0_out = cand_r.wp0;
      end
      if (strong_r && aq_r) begin
        out_nxt.q0_out = cand_r.sq0;
        out_nxt.q1_out = cand_r.sq1;
        out_nxt.q2_out = cand_r.sq2;
      end else begin
        out_nxt.q0_out = cand_r.wq0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------- checks
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (ia_r <= QP_MAX) && (ib_r <= QP_MAX))
    else $error("clipped table index above range");

  a_filt_needs_bs: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && filt_r) |-> (s3_data_r.bs != '0))
    else $error("line marked filtered with zero strength");

  a_drain_open: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output side drains");

  a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> (v2_r && $stable(s2_data_r)))
    else $error("stage 2 item lost during stall");

endmodule
